// ===== src/fwcf_pkg.sv =====
// ----------------------------------------------------------------------------
// fwcf_pkg: shared definitions for the frame window capture fifo
// Operation codes, default sizes, fixed field widths and the ring control
// bundle passed from the capture gate to the sample ring.
// ----------------------------------------------------------------------------
`default_nettype none

package fwcf_pkg;

	// default sizes
	localparam int DEPTH_DEF     = 4096;
	localparam int MAX_BLOCK_DEF = 4096;

	// fixed field widths
	localparam int OP_W      = 3;
	localparam int FRAME_W   = 64;
	localparam int SIN_W     = 32;
	localparam int SMP_W     = 16;
	localparam int BLK_W     = 13;
	localparam int QDEPTH_W  = 13;
	localparam int CNT32_W   = 32;
	localparam int CNT16_W   = 16;

	// operation codes
	localparam logic [OP_W-1:0] OP_SAMPLE = 3'd0;
	localparam logic [OP_W-1:0] OP_DRAIN  = 3'd1;
	localparam logic [OP_W-1:0] OP_START  = 3'd2;
	localparam logic [OP_W-1:0] OP_STOP   = 3'd3;
	localparam logic [OP_W-1:0] OP_ARM    = 3'd4;
	localparam logic [OP_W-1:0] OP_CANCEL = 3'd5;

	// ring control for one transfer
	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} ring_ctl_t;

endpackage

`default_nettype wire

// ===== src/fwcf_ring.sv =====
// ----------------------------------------------------------------------------
// fwcf_ring: sample ring buffer
// One synchronous memory with a registered read port, write and read
// indices and a fill count. Push and pop never occur in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fwcf_ring #(
	parameter int DEPTH = fwcf_pkg::DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire fwcf_pkg::ring_ctl_t                ctl,
	input  wire logic [fwcf_pkg::SMP_W-1:0]         wr_data,
	output logic      [$clog2(DEPTH+1)-1:0]         used,
	output logic      [fwcf_pkg::SMP_W-1:0]         rd_data
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	logic [fwcf_pkg::SMP_W-1:0] mem [DEPTH];
	logic [AW-1:0]              wr_idx_q;
	logic [AW-1:0]              rd_idx_q;
	logic [CW-1:0]              used_q;
	logic [fwcf_pkg::SMP_W-1:0] rd_q;

	// index and fill bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			used_q   <= '0;
		end else if (ctl.clear) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			used_q   <= '0;
		end else if (ctl.push) begin
			wr_idx_q <= (wr_idx_q == AW'(DEPTH-1)) ? '0 : wr_idx_q + 1'b1;
			used_q   <= used_q + 1'b1;
		end else if (ctl.pop) begin
			rd_idx_q <= (rd_idx_q == AW'(DEPTH-1)) ? '0 : rd_idx_q + 1'b1;
			used_q   <= used_q - 1'b1;
		end
	end

	// memory write port
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[wr_idx_q] <= wr_data;
		end
	end

	// memory read port, data held until the next pop
	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			rd_q <= mem[rd_idx_q];
		end
	end

	assign used    = used_q;
	assign rd_data = rd_q;

endmodule

`default_nettype wire

// ===== src/frame_window_capture_fifo_core.sv =====
// ----------------------------------------------------------------------------
// frame_window_capture_fifo_core: frame-gated audio capture into a sample fifo
// Control events, audio samples and drain requests in; one status result out
// for every input transfer.
// ----------------------------------------------------------------------------
// Every input transfer (sample, drain, start, stop, arm, cancel) yields exactly
// one result transfer carrying the status after that item. A new item is taken
// every clock cycle: the gate updates its state in the accept cycle, a drain
// issues its read of the sample memory in the same cycle, and the memory read
// latency is covered by a holding stage ahead of the output register, so a
// result passes through the holding stage and then the output register; the
// input stalls only when both of those stages are full and the output is
// stalled. No clearing pass is needed after reset; an arm while neither armed
// nor recording empties the queue at once.
`default_nettype none

module frame_window_capture_fifo_core #(
	parameter int DEPTH     = fwcf_pkg::DEPTH_DEF,
	parameter int MAX_BLOCK = fwcf_pkg::MAX_BLOCK_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [fwcf_pkg::OP_W-1:0]         op,
	input  wire logic [fwcf_pkg::FRAME_W-1:0]      frame,
	input  wire logic signed [fwcf_pkg::SIN_W-1:0] sample_in,
	input  wire logic [fwcf_pkg::BLK_W-1:0]        block_frames,
	input  wire logic                              first_in_block,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   sample_valid,
	output logic signed [fwcf_pkg::SMP_W-1:0]      sample_out,
	output logic                                   is_armed,
	output logic                                   is_recording,
	output logic                                   done_res,
	output logic [fwcf_pkg::QDEPTH_W-1:0]          queue_depth,
	output logic [fwcf_pkg::CNT32_W-1:0]           lost_samples,
	output logic [fwcf_pkg::CNT16_W-1:0]           lost_windows,
	output logic [fwcf_pkg::CNT32_W-1:0]           pushed_samples
);

	localparam int CW = $clog2(DEPTH+1);
	localparam int PB = $clog2(MAX_BLOCK+1);
	localparam int FW = fwcf_pkg::FRAME_W;

	// gate state
	logic          armed_q, rec_q, start_pend_q, stop_pend_q, fin_q, wacc_q, fae_q;
	logic [FW-1:0] start_target_q, stop_target_q;
	logic [PB-1:0] bpos_q, wfirst_q, wlast_q;
	logic [31:0]   drop_q, queued_q;
	logic [15:0]   drop_ev_q;

	logic          armed_d, rec_d, start_pend_d, stop_pend_d, fin_d, wacc_d, fae_d;
	logic [FW-1:0] start_target_d, stop_target_d;
	logic [PB-1:0] bpos_d, wfirst_d, wlast_d;
	logic [31:0]   drop_d, queued_d;
	logic [15:0]   drop_ev_d;

	// handshake and pipeline
	logic in_acc, adv, v_s1, popped_s1, out_v_q;
	fwcf_pkg::ring_ctl_t           ctl;
	logic [CW-1:0]                 used;
	logic [fwcf_pkg::SMP_W-1:0]    rd_data;

	// window arithmetic
	logic [FW-1:0] d_start, e_stop;
	logic [PB-1:0] n_blk, win_first, win_last, cnt, pos;
	logic          win_go, win_fin;
	logic [31:0]   space;
	logic [32:0]   drop_sum;

	// output registers
	logic                       sample_valid_q, is_armed_q, is_rec_q, done_q;
	logic [fwcf_pkg::SMP_W-1:0] sample_out_q;
	logic [CW-1:0]              used_out_q;
	logic [31:0]                drop_out_q, queued_out_q;
	logic [15:0]                drop_ev_out_q;

	// transfer control
	assign in_acc   = in_valid && !in_stall;
	assign adv      = v_s1 && (!out_v_q || !out_stall);
	assign in_stall = v_s1 && out_v_q && out_stall;

	// frame distances from the block start
	assign d_start = start_target_q - frame;
	assign e_stop  = stop_target_q - frame;

	// block length limited to the largest block
	assign n_blk = (32'(block_frames) > 32'(MAX_BLOCK)) ? PB'(MAX_BLOCK) : PB'(block_frames);

	// free space and saturating drop sum
	assign space    = 32'(DEPTH) - 32'(used);
	assign drop_sum = 33'(drop_q) + 33'(cnt);

	// next state for one transfer
	always_comb begin
		armed_d        = armed_q;
		rec_d          = rec_q;
		start_pend_d   = start_pend_q;
		stop_pend_d    = stop_pend_q;
		fin_d          = fin_q;
		wacc_d         = wacc_q;
		fae_d          = fae_q;
		start_target_d = start_target_q;
		stop_target_d  = stop_target_q;
		bpos_d         = bpos_q;
		wfirst_d       = wfirst_q;
		wlast_d        = wlast_q;
		drop_d         = drop_q;
		drop_ev_d      = drop_ev_q;
		queued_d       = queued_q;
		ctl            = '0;
		win_first      = '0;
		win_last       = n_blk;
		win_go         = 1'b0;
		win_fin        = 1'b0;
		cnt            = '0;
		pos            = '0;
		if (in_acc) begin
			unique case (op)
				fwcf_pkg::OP_SAMPLE: begin
					if (first_in_block) begin
						// a block cut short closes the take first
						if (fae_d) begin
							armed_d = 1'b0;
							rec_d   = 1'b0;
							fin_d   = 1'b1;
							wacc_d  = 1'b0;
							fae_d   = 1'b0;
						end
						// open the copy window for this block
						wacc_d = 1'b0;
						fae_d  = 1'b0;
						bpos_d = '0;
						if (armed_d && n_blk != '0 && start_pend_q) begin
							win_go = 1'b1;
							if (!rec_d) begin
								if (start_target_q > frame) begin
									if (FW'(n_blk) <= d_start) begin
										win_go = 1'b0;
									end else begin
										win_first = PB'(d_start);
									end
								end
								if (win_go) begin
									rec_d = 1'b1;
								end
							end
							if (win_go && stop_pend_q) begin
								if (stop_target_q <= frame) begin
									armed_d = 1'b0;
									rec_d   = 1'b0;
									fin_d   = 1'b1;
									wacc_d  = 1'b0;
									fae_d   = 1'b0;
									win_go  = 1'b0;
								end else begin
									if (e_stop < FW'(n_blk)) begin
										win_last = PB'(e_stop);
									end
									win_fin = (FW'(n_blk) >= e_stop);
								end
							end
							if (win_go) begin
								if (win_last > win_first) begin
									cnt = win_last - win_first;
									if (space < 32'(cnt)) begin
										drop_d = drop_sum[32] ? '1 : drop_sum[31:0];
										if (drop_ev_q != '1) begin
											drop_ev_d = drop_ev_q + 1'b1;
										end
									end else begin
										wacc_d   = 1'b1;
										wfirst_d = win_first;
										wlast_d  = win_last;
									end
								end
								fae_d = win_fin;
							end
						end
					end
					// push when the position lies in the window
					pos = bpos_d;
					if (wacc_d && pos >= wfirst_d && pos < wlast_d && used < CW'(DEPTH)) begin
						ctl.push = 1'b1;
						if (queued_q != '1) begin
							queued_d = queued_q + 1'b1;
						end
					end
					// finalize at the end of the block
					if (fae_d && (32'(pos) + 32'd1) >= 32'(n_blk)) begin
						armed_d = 1'b0;
						rec_d   = 1'b0;
						fin_d   = 1'b1;
						wacc_d  = 1'b0;
						fae_d   = 1'b0;
					end
					if (bpos_d < PB'(MAX_BLOCK)) begin
						bpos_d = bpos_d + 1'b1;
					end
				end
				fwcf_pkg::OP_DRAIN: begin
					if (used != '0) begin
						ctl.pop = 1'b1;
					end
				end
				fwcf_pkg::OP_START: begin
					if (armed_q) begin
						start_target_d = frame;
						start_pend_d   = 1'b1;
					end
				end
				fwcf_pkg::OP_STOP: begin
					if (armed_q || rec_q) begin
						stop_target_d = frame;
						stop_pend_d   = 1'b1;
					end
				end
				fwcf_pkg::OP_ARM: begin
					if (!armed_q && !rec_q) begin
						ctl.clear      = 1'b1;
						drop_d         = '0;
						drop_ev_d      = '0;
						queued_d       = '0;
						start_target_d = '0;
						stop_target_d  = '0;
						start_pend_d   = 1'b0;
						stop_pend_d    = 1'b0;
						fin_d          = 1'b0;
						wacc_d         = 1'b0;
						fae_d          = 1'b0;
						armed_d        = 1'b1;
					end
				end
				fwcf_pkg::OP_CANCEL: begin
					armed_d = 1'b0;
					rec_d   = 1'b0;
					fin_d   = 1'b1;
					wacc_d  = 1'b0;
					fae_d   = 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// gate state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q        <= 1'b0;
			rec_q          <= 1'b0;
			start_pend_q   <= 1'b0;
			stop_pend_q    <= 1'b0;
			fin_q          <= 1'b0;
			wacc_q         <= 1'b0;
			fae_q          <= 1'b0;
			start_target_q <= '0;
			stop_target_q  <= '0;
			bpos_q         <= '0;
			wfirst_q       <= '0;
			wlast_q        <= '0;
			drop_q         <= '0;
			drop_ev_q      <= '0;
			queued_q       <= '0;
		end else begin
			armed_q        <= armed_d;
			rec_q          <= rec_d;
			start_pend_q   <= start_pend_d;
			stop_pend_q    <= stop_pend_d;
			fin_q          <= fin_d;
			wacc_q         <= wacc_d;
			fae_q          <= fae_d;
			start_target_q <= start_target_d;
			stop_target_q  <= stop_target_d;
			bpos_q         <= bpos_d;
			wfirst_q       <= wfirst_d;
			wlast_q        <= wlast_d;
			drop_q         <= drop_d;
			drop_ev_q      <= drop_ev_d;
			queued_q       <= queued_d;
		end
	end

	// sample ring
	fwcf_ring #(
		.DEPTH(DEPTH)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.wr_data (sample_in[fwcf_pkg::SIN_W-1 -: fwcf_pkg::SMP_W]),
		.used    (used),
		.rd_data (rd_data)
	);

	// read latency stage and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			popped_s1 <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (in_acc) begin
				v_s1      <= 1'b1;
				popped_s1 <= ctl.pop;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// output register, status taken while the gate state is held
	always_ff @(posedge clk) begin
		if (adv) begin
			sample_valid_q <= popped_s1;
			sample_out_q   <= popped_s1 ? rd_data : '0;
			is_armed_q     <= armed_q && !fin_q;
			is_rec_q       <= rec_q;
			done_q         <= fin_q && (used == '0);
			used_out_q     <= used;
			drop_out_q     <= drop_q;
			drop_ev_out_q  <= drop_ev_q;
			queued_out_q   <= queued_q;
		end
	end

	assign out_valid      = out_v_q;
	assign sample_valid   = sample_valid_q;
	assign sample_out     = sample_out_q;
	assign is_armed       = is_armed_q;
	assign is_recording   = is_rec_q;
	assign done_res       = done_q;
	assign queue_depth    = fwcf_pkg::QDEPTH_W'(used_out_q);
	assign lost_samples   = drop_out_q;
	assign lost_windows   = drop_ev_out_q;
	assign pushed_samples = queued_out_q;

	// fill count never passes the ring size
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used <= CW'(DEPTH))
		else $error("ring fill count above depth");

	// popped data held while the read stage waits
	a_rd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && popped_s1 && !adv) |=> $stable(rd_data))
		else $error("read data changed while waiting for output");

	// armed and done exclude each other
	a_armed_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(is_armed && done_res))
		else $error("armed and done reported together");

	// input stalls only with both stages full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && out_v_q))
		else $error("input stalled with a free stage");

endmodule

`default_nettype wire
